/* sv/twv_pkg.sv */
package twv_pkg;

   localparam int HEIGHT_W        = 16;
   localparam int TOTAL_W         = 26;
   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_HEIGHT_BITS = 16;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // take one request
      logic back_init;   // last request taken: set up backward pass
      logic back_issue;  // backward pass: read one column, step down
      logic fwd_init;    // set up forward pass
      logic fwd_issue;   // forward pass: read one column, step up
      logic finish;      // load result register, clear sequence state
   } twv_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic idx_zero;    // index sits on the first column
      logic idx_last;    // index sits on the last stored column
      logic out_free;    // result register can take a new result
   } twv_status_type;

endpackage

/* sv/twv_if.sv */
interface twv_req_if;
   logic                           valid;
   logic                           ready;
   logic [twv_pkg::HEIGHT_W-1:0]   column_height;
   logic                           is_last;

   modport source (output valid, output column_height, output is_last, input ready);
   modport sink   (input valid, input column_height, input is_last, output ready);
endinterface

interface twv_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [twv_pkg::TOTAL_W-1:0]    water_total;
   logic                           length_overflow;

   modport source (output valid, output water_total, output length_overflow, input ready);
   modport sink   (input valid, input water_total, input length_overflow, output ready);
endinterface

/* sv/twv_ctrl.sv */
module twv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_is_last,
   output logic                    req_ready,
   input  twv_pkg::twv_status_type sts,
   output twv_pkg::twv_cmd_type    cmd
);
   import twv_pkg::*;

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_BACK   = 3'd1;
   localparam logic [2:0] S_BDRAIN = 3'd2;
   localparam logic [2:0] S_FWD    = 3'd3;
   localparam logic [2:0] S_FDRAIN = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready     = 1'b1;
            cmd.accept    = req_valid;
            cmd.back_init = req_valid & req_is_last;
            if (req_valid && req_is_last) begin
               state_in = S_BACK;
            end
         end
         S_BACK: begin
            cmd.back_issue = 1'b1;
            if (sts.idx_zero) begin
               state_in = S_BDRAIN;
            end
         end
         S_BDRAIN: begin
            cmd.fwd_init = 1'b1;
            state_in     = S_FWD;
         end
         S_FWD: begin
            cmd.fwd_issue = 1'b1;
            if (sts.idx_last) begin
               state_in = S_FDRAIN;
            end
         end
         S_FDRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

/* sv/twv_dp.sv */
module twv_dp #(
   parameter int MAX_COLUMNS = twv_pkg::DEF_MAX_COLUMNS,
   parameter int HEIGHT_BITS = twv_pkg::DEF_HEIGHT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  twv_pkg::twv_cmd_type         cmd,
   output twv_pkg::twv_status_type      sts,
   input  logic [twv_pkg::HEIGHT_W-1:0] req_column_height,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [twv_pkg::TOTAL_W-1:0]  rsp_water_total,
   output logic                         rsp_length_overflow
);
   import twv_pkg::*;

   localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
   localparam int ADDR_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int STORE_W = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_COLUMNS - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_COLUMNS);

   logic [STORE_W-1:0] height_mem [MAX_COLUMNS];
   logic [STORE_W-1:0] rmax_mem   [MAX_COLUMNS];

   logic [CNT_W-1:0]   count_ff;
   logic               ovf_ff;
   logic [ADDR_W-1:0]  idx_ff;
   logic [ADDR_W-1:0]  addr_d_ff;
   logic               rd_vld_ff;
   logic               fwd_ff;
   logic [STORE_W-1:0] h_rd_ff;
   logic [STORE_W-1:0] r_rd_ff;
   logic [STORE_W-1:0] run_ff;
   logic [STORE_W-1:0] left_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               rsp_valid_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_ovf_ff;

   logic               has_room;
   logic [CNT_W-1:0]   count_m1;
   logic [STORE_W-1:0] lim;
   logic [TOTAL_W:0]   sum;

   assign has_room = count_ff < CNT_MAX;
   assign count_m1 = count_ff - CNT_W'(1);
   assign lim      = (left_ff < r_rd_ff) ? left_ff : r_rd_ff;
   assign sum      = {1'b0, total_ff} + (TOTAL_W + 1)'(lim - h_rd_ff);

   assign sts.idx_zero = (idx_ff == '0);
   assign sts.idx_last = (idx_ff == count_m1[ADDR_W-1:0]);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // height store: written while loading, read by both passes
   always_ff @(posedge clock) begin
      if (cmd.accept && has_room) begin
         height_mem[count_ff[ADDR_W-1:0]] <= req_column_height[STORE_W-1:0];
      end
      h_rd_ff <= height_mem[idx_ff];
   end

   // right-max store: written by the backward pass, read by the forward pass
   always_ff @(posedge clock) begin
      if (rd_vld_ff && !fwd_ff) begin
         rmax_mem[addr_d_ff] <= run_ff;
      end
      r_rd_ff <= rmax_mem[idx_ff];
   end

   // pass datapath
   always_ff @(posedge clock) begin
      addr_d_ff <= idx_ff;
      if (cmd.back_init) begin
         idx_ff   <= has_room ? count_ff[ADDR_W-1:0] : LAST_ADDR;
         run_ff   <= '0;
         left_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.back_issue) begin
         idx_ff <= idx_ff - ADDR_W'(1);
      end else if (cmd.fwd_init) begin
         idx_ff <= '0;
      end else if (cmd.fwd_issue) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
      if (rd_vld_ff && !fwd_ff) begin
         if (h_rd_ff > run_ff) begin
            run_ff <= h_rd_ff;
         end
      end
      if (rd_vld_ff && fwd_ff) begin
         if (lim > h_rd_ff) begin
            total_ff <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
         end
         if (h_rd_ff > left_ff) begin
            left_ff <= h_rd_ff;
         end
      end
      rsp_total_ff <= cmd.finish ? total_ff : rsp_total_ff;
      rsp_ovf_ff   <= cmd.finish ? ovf_ff : rsp_ovf_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.back_issue | cmd.fwd_issue;
         if (cmd.back_init) begin
            fwd_ff <= 1'b0;
         end else if (cmd.fwd_init) begin
            fwd_ff <= 1'b1;
         end
         if (cmd.finish) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else if (cmd.accept) begin
            if (has_room) begin
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_water_total     = rsp_total_ff;
   assign rsp_length_overflow = rsp_ovf_ff;

endmodule

/* sv/trapped_water_volume.sv */
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   column_height[15:0], is_last
// rsp_chan  out  valid/ready   water_total[25:0], length_overflow
//
// Columns load one per cycle into the height store while req ready is high.
// After the column marked last, a backward pass and its drain step fill the
// right-max store, then a forward pass and its drain step sum the water. The
// result register is loaded next, once it is free. Each pass reads the stores
// one column at a time through their single read ports.
// Reset is synchronous, active high, and clears counters and control only.
// Requests stall (req ready low) from the last column until the result is loaded
// into the output register; a stalled result holds there while loading resumes.
module trapped_water_volume #(
   parameter int MAX_COLUMNS = twv_pkg::DEF_MAX_COLUMNS,
   parameter int HEIGHT_BITS = twv_pkg::DEF_HEIGHT_BITS
) (
   input logic       clock,
   input logic       reset,
   twv_req_if.sink   req_chan,
   twv_rsp_if.source rsp_chan
);
   import twv_pkg::*;

   // command and status between controller and datapath
   twv_cmd_type    cmd;
   twv_status_type sts;
   logic           req_ready;

   // sequence the load, backward pass, forward pass and result hand-off
   twv_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_is_last (req_chan.is_last),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // stores, running maxima, accumulator and result register
   twv_dp #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_column_height   (req_chan.column_height),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_water_total     (rsp_chan.water_total),
      .rsp_length_overflow (rsp_chan.length_overflow)
   );

   // accept requests only while loading
   assign req_chan.ready = req_ready;

endmodule
